// File: design/sadpcm_pkg.sv
// Shared types, constants and tables for the stereo ADPCM nibble decoder.
package sadpcm_pkg;

  localparam int unsigned IDX_W   = 7;
  localparam int unsigned STEP_W  = 15;
  localparam int unsigned PCM_W   = 16;
  localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;
  localparam logic signed [PCM_W+1:0] PCM_MAX = 18'sd32767;
  localparam logic signed [PCM_W+1:0] PCM_MIN = -18'sd32768;

  // Quantizer step sizes, indexed by the step index.
  localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
    15'h0007, 15'h0008, 15'h0009, 15'h000A, 15'h000B, 15'h000C, 15'h000D, 15'h000F,
    15'h0010, 15'h0012, 15'h0013, 15'h0015, 15'h0017, 15'h001A, 15'h001C, 15'h001F,
    15'h0022, 15'h0026, 15'h0029, 15'h002E, 15'h0032, 15'h0037, 15'h003D, 15'h0043,
    15'h004A, 15'h0051, 15'h0059, 15'h0062, 15'h006C, 15'h0076, 15'h0082, 15'h008F,
    15'h009E, 15'h00AD, 15'h00BF, 15'h00D2, 15'h00E7, 15'h00FE, 15'h0117, 15'h0133,
    15'h0152, 15'h0174, 15'h0199, 15'h01C2, 15'h01EF, 15'h0220, 15'h0256, 15'h0292,
    15'h02D4, 15'h031D, 15'h036C, 15'h03C4, 15'h0424, 15'h048E, 15'h0503, 15'h0583,
    15'h0610, 15'h06AC, 15'h0756, 15'h0812, 15'h08E1, 15'h09C4, 15'h0ABE, 15'h0BD1,
    15'h0CFF, 15'h0E4C, 15'h0FBA, 15'h114D, 15'h1308, 15'h14EF, 15'h1707, 15'h1954,
    15'h1BDD, 15'h1EA6, 15'h21B7, 15'h2516, 15'h28CB, 15'h2CDF, 15'h315C, 15'h364C,
    15'h3BBA, 15'h41B2, 15'h4844, 15'h4F7E, 15'h5771, 15'h6030, 15'h69CE, 15'h7463,
    15'h7FFF
  };

  // Request from the top level to one channel lane.
  typedef struct packed {
    logic             en;
    logic             load;
    logic [3:0]       code;
    logic [IDX_W-1:0] start_index;
  } lane_req_t;

  // Step index adjustment for a 3-bit magnitude.
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

// File: design/sadpcm_lane.sv
// One channel decoder lane: predictor and step index state plus the nibble update.
module sadpcm_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sadpcm_pkg::lane_req_t              req,
  output logic signed [sadpcm_pkg::PCM_W-1:0] sample
);
  import sadpcm_pkg::*;

  logic signed [PCM_W-1:0] pred_r, pred_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        cur;
  logic [2:0]              mag;
  logic [STEP_W-1:0]       step;
  logic [STEP_W+3:0]       prod;
  logic [PCM_W-1:0]        diff;
  logic signed [PCM_W+1:0] sum;
  logic signed [4:0]       adj;
  logic signed [IDX_W+1:0] ni;

  always_comb begin
    if (req.load) begin
      cur = (req.start_index > IDX_MAX) ? IDX_MAX : req.start_index;
    end else begin
      cur = idx_r;
    end
    mag  = req.code[2:0];
    step = STEP_TABLE[cur];
    prod = {15'd0, mag, 1'b1} * {4'd0, step};
    diff = prod[STEP_W+3:3];
    if (req.code[3]) begin
      sum = {{2{pred_r[PCM_W-1]}}, pred_r} - $signed({2'b00, diff});
    end else begin
      sum = {{2{pred_r[PCM_W-1]}}, pred_r} + $signed({2'b00, diff});
    end
    if (sum > PCM_MAX) begin
      pred_nxt = PCM_MAX[PCM_W-1:0];
    end else if (sum < PCM_MIN) begin
      pred_nxt = PCM_MIN[PCM_W-1:0];
    end else begin
      pred_nxt = sum[PCM_W-1:0];
    end
    adj = index_adjust(mag);
    ni  = $signed({2'b00, cur}) + $signed({{(IDX_W-3){adj[4]}}, adj});
    if (ni < 0) begin
      idx_nxt = '0;
    end else if (ni > $signed({2'b00, IDX_MAX})) begin
      idx_nxt = IDX_MAX;
    end else begin
      idx_nxt = ni[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r <= '0;
      idx_r  <= '0;
    end else if (req.en) begin
      pred_r <= pred_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign sample = pred_nxt;

endmodule

// File: design/sadpcm_merge.sv
// Merging stage: joins both lane samples into one result and buffers it in a two-entry skid queue.
module sadpcm_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  logic signed [sadpcm_pkg::PCM_W-1:0] left_sample,
  input  logic signed [sadpcm_pkg::PCM_W-1:0] right_sample,
  output logic                               has_room,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [2*sadpcm_pkg::PCM_W-1:0]     out_tdata
);
  import sadpcm_pkg::*;

  logic [2*PCM_W-1:0] buf_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         count_r;
  logic               pop;

  assign has_room   = (count_r != 2'd2);
  assign out_tvalid = (count_r != 2'd0);
  assign out_tdata  = buf_r[rd_ptr_r];
  assign pop        = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= {right_sample, left_sample};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// File: design/stereo_adpcm_nibble_decoder.sv
// Top level of the stereo 4-bit ADPCM nibble decoder.
//
// Each input transaction carries one code byte: the high nibble is decoded
// by the left lane and the low nibble by the right lane, both in the same
// cycle, and one output transaction with both 16-bit samples follows. The
// block takes one transaction per clock cycle while in_tready is high, and
// registers each result into the output queue when it accepts the input. The
// rate rests on the per-channel update loop (step table read, small multiply,
// add and saturate, index clamp) being combinational in each lane. A two-entry
// queue behind the lanes lets the block keep accepting while a finished result
// waits to be taken; in_tready drops only when both entries are occupied. When
// tuser is set, both step indices are reloaded from the header fields (values
// above 88 are treated as 88) before the byte is decoded; predictors carry over.
module stereo_adpcm_nibble_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] data_byte, [14:8] start_index_left, [21:15] start_index_right, [23:22] zero
  input  logic [23:0] in_tdata,
  // [0] chunk_start
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] left_sample, [31:16] right_sample
  output logic [31:0] out_tdata
);
  import sadpcm_pkg::*;

  logic                    accept;
  logic                    has_room;
  lane_req_t               left_req, right_req;
  logic signed [PCM_W-1:0] left_sample, right_sample;

  // A transaction is taken whenever the output queue has a free entry.
  assign in_tready = has_room;
  assign accept    = in_tvalid && in_tready;

  // The lanes only advance their state on an accepted transaction.
  always_comb begin
    left_req.en           = accept;
    left_req.load         = in_tuser[0];
    left_req.code         = in_tdata[7:4];
    left_req.start_index  = in_tdata[14:8];
    right_req.en          = accept;
    right_req.load        = in_tuser[0];
    right_req.code        = in_tdata[3:0];
    right_req.start_index = in_tdata[21:15];
  end

  sadpcm_lane u_left_lane (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (left_req),
    .sample (left_sample)
  );

  sadpcm_lane u_right_lane (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (right_req),
    .sample (right_sample)
  );

  sadpcm_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (accept),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .has_room     (has_room),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

// File: test/stereo_adpcm_nibble_decoder_tb.sv
// Self-checking testbench for the stereo 4-bit ADPCM nibble decoder.
module stereo_adpcm_nibble_decoder_tb;

  // Quantizer step sizes, indexed by a channel's step index (0..88).
  localparam int STEP_SIZES [0:88] = '{
    'h0007, 'h0008, 'h0009, 'h000A, 'h000B, 'h000C, 'h000D, 'h000F,
    'h0010, 'h0012, 'h0013, 'h0015, 'h0017, 'h001A, 'h001C, 'h001F,
    'h0022, 'h0026, 'h0029, 'h002E, 'h0032, 'h0037, 'h003D, 'h0043,
    'h004A, 'h0051, 'h0059, 'h0062, 'h006C, 'h0076, 'h0082, 'h008F,
    'h009E, 'h00AD, 'h00BF, 'h00D2, 'h00E7, 'h00FE, 'h0117, 'h0133,
    'h0152, 'h0174, 'h0199, 'h01C2, 'h01EF, 'h0220, 'h0256, 'h0292,
    'h02D4, 'h031D, 'h036C, 'h03C4, 'h0424, 'h048E, 'h0503, 'h0583,
    'h0610, 'h06AC, 'h0756, 'h0812, 'h08E1, 'h09C4, 'h0ABE, 'h0BD1,
    'h0CFF, 'h0E4C, 'h0FBA, 'h114D, 'h1308, 'h14EF, 'h1707, 'h1954,
    'h1BDD, 'h1EA6, 'h21B7, 'h2516, 'h28CB, 'h2CDF, 'h315C, 'h364C,
    'h3BBA, 'h41B2, 'h4844, 'h4F7E, 'h5771, 'h6030, 'h69CE, 'h7463,
    'h7FFF
  };

  localparam int TOP_INDEX   = sadpcm_pkg::IDX_MAX;
  localparam int RANDOM_BYTES = 2000;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;

  // One decoded stereo sample pair.
  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } pcm_pair_t;

  // Direction in which the random code signs lean during one chunk, so that
  // the predictors are pushed into saturation now and then.
  typedef enum int {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_t;

  // Tracks the decoder state and holds the sample pairs still owed by the block.
  class pcm_scoreboard;
    logic signed [15:0] left_pred;
    logic signed [15:0] right_pred;
    logic [6:0]         left_idx;
    logic [6:0]         right_idx;
    pcm_pair_t          pairs_due[$];
    int                 fail_count;

    function new();
      left_pred  = '0;
      right_pred = '0;
      left_idx   = '0;
      right_idx  = '0;
      fail_count = 0;
    endfunction

    // Advances one channel by one 4-bit code.
    function void decode_nibble(input logic [3:0] code, inout logic signed [15:0] pred,
                                inout logic [6:0] idx);
      int mag;
      int diff;
      int sum;
      int next_idx;
      mag  = code[2:0];
      diff = ((2 * mag + 1) * STEP_SIZES[idx]) >>> 3;
      sum  = pred;
      sum  = code[3] ? sum - diff : sum + diff;
      if (sum > 32767) begin
        sum = 32767;
      end else if (sum < -32768) begin
        sum = -32768;
      end
      pred = sum[15:0];
      next_idx = idx;
      next_idx += (mag >= 4) ? 2 * (mag - 3) : -1;
      if (next_idx < 0) begin
        next_idx = 0;
      end else if (next_idx > TOP_INDEX) begin
        next_idx = TOP_INDEX;
      end
      idx = next_idx[6:0];
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(input logic [7:0] code_byte, input logic chunk_start,
                            input logic [6:0] start_left, input logic [6:0] start_right);
      pcm_pair_t pair;
      if (chunk_start) begin
        left_idx  = (start_left > TOP_INDEX) ? 7'(TOP_INDEX) : start_left;
        right_idx = (start_right > TOP_INDEX) ? 7'(TOP_INDEX) : start_right;
      end
      decode_nibble(code_byte[7:4], left_pred, left_idx);
      decode_nibble(code_byte[3:0], right_pred, right_idx);
      pair.left  = left_pred;
      pair.right = right_pred;
      pairs_due.push_back(pair);
    endfunction

    // Called for every accepted output transaction.
    function void check_samples(input logic [31:0] got);
      pcm_pair_t want;
      if (pairs_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected output transaction: left %0d right %0d",
                   $signed(got[15:0]), $signed(got[31:16]));
        end
      end else begin
        want = pairs_due.pop_front();
        if (got[15:0] !== want.left || got[31:16] !== want.right) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("sample mismatch: left expected %0d got %0d, right expected %0d got %0d",
                     want.left, $signed(got[15:0]), want.right, $signed(got[31:16]));
          end
        end
      end
    endfunction

    function int outstanding();
      return pairs_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  // When cleared, neither side idles; the random phase clears it for a stretch.
  bit            idle_enabled = 1'b1;
  int            cycle_count = 0;
  pcm_scoreboard scoreboard = new();

  stereo_adpcm_nibble_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Watchdog: a correct run finishes far below this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // While idle_enabled is set, the result side stalls at random about 16 percent
  // of the time. The values read here are the ones that held just before the
  // edge, so the check sees exactly the transaction that the edge completed.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(idle_enabled && $urandom_range(99) < 16);
    end
    if (rst_n && out_tvalid && out_tready) begin
      scoreboard.check_samples(out_tdata);
    end
  end

  // Offers one code byte, possibly after a few idle cycles, and returns at
  // the edge where the input transaction completes. Each pass through the
  // idle loop and the final drive happen in distinct time steps, so tvalid
  // never gets two assignments in one step.
  task automatic send_code(input logic [7:0] code_byte, input logic chunk_start,
                           input logic [6:0] start_left, input logic [6:0] start_right);
    while (idle_enabled && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, start_right, start_left, code_byte};
    in_tuser  <= chunk_start;
    do @(posedge clk); while (!in_tready);
    scoreboard.note_byte(code_byte, chunk_start, start_left, start_right);
  endtask

  // Holds the input side quiet until every owed sample pair has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (scoreboard.outstanding() > 0) @(posedge clk);
  endtask

  // Step index for a chunk header: mostly legal, sometimes above 88 so that
  // the saturation of the header value is exercised.
  function automatic logic [6:0] header_index();
    return ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(88));
  endfunction

  initial begin
    drift_t     drift;
    logic [7:0] code_byte;
    logic       chunk_start;
    logic [6:0] start_left;
    logic [6:0] start_right;

    drift = DRIFT_NONE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Zero magnitudes at index 0 check the lower index clamp;
    // header fields without a chunk start must be ignored.
    send_code(8'h00, 1'b0, 7'd0, 7'd0);
    send_code(8'h88, 1'b0, 7'h7F, 7'h7F);
    send_code(8'h33, 1'b0, 7'd50, 7'd60);
    // Largest steps with largest magnitudes: both channels hit the positive
    // rail at once and the index sticks at the upper clamp.
    send_code(8'h77, 1'b1, 7'd88, 7'd88);
    send_code(8'h77, 1'b0, 7'd0, 7'd0);
    send_code(8'h77, 1'b0, 7'd0, 7'd0);
    // Now the negative rail.
    send_code(8'hFF, 1'b0, 7'd0, 7'd0);
    send_code(8'hFF, 1'b0, 7'd0, 7'd0);
    send_code(8'hFF, 1'b0, 7'd0, 7'd0);
    // Header indices above 88 saturate; the channels head to opposite rails.
    send_code(8'h7F, 1'b1, 7'd127, 7'd89);
    send_code(8'h7F, 1'b0, 7'd0, 7'd0);
    send_code(8'hF7, 1'b0, 7'd0, 7'd0);
    // A chunk start back at the smallest step: predictors carry over.
    send_code(8'h12, 1'b1, 7'd0, 7'd0);
    send_code(8'h34, 1'b0, 7'd0, 7'd0);
    send_code(8'h56, 1'b0, 7'd0, 7'd0);
    send_code(8'h9A, 1'b1, 7'd1, 7'd87);
    send_code(8'hBC, 1'b0, 7'd0, 7'd0);
    send_code(8'hDE, 1'b0, 7'd0, 7'd0);
    send_code(8'h4C, 1'b1, 7'd64, 7'd32);
    send_code(8'hE5, 1'b1, 7'd90, 7'd3);
    wait_drained();

    // Random part. Chunk starts are occasional; within a chunk the code signs
    // may lean one way so the predictors reach the rails from either side.
    for (int n = 0; n < RANDOM_BYTES; n++) begin
      idle_enabled = !(n >= 900 && n < 1200);
      if (n == 1500) begin
        wait_drained();
      end
      chunk_start = ($urandom_range(99) < 4);
      if (chunk_start) begin
        start_left  = header_index();
        start_right = header_index();
        drift = drift_t'($urandom_range(2));
      end else begin
        start_left  = 7'($urandom_range(127));
        start_right = 7'($urandom_range(127));
      end
      code_byte = 8'($urandom_range(255));
      if (drift != DRIFT_NONE && $urandom_range(9) < 8) begin
        code_byte[7] = (drift == DRIFT_DOWN);
        code_byte[3] = (drift == DRIFT_DOWN);
      end
      send_code(code_byte, chunk_start, start_left, start_right);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scoreboard.fail_count == 0 && scoreboard.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
